FILE: rtl/pcde_pkg.sv
// Shared types, codes and helpers for the canvas descriptor extractor.
`default_nettype none
package pcde_pkg;

  localparam int FN_W  = 29;
  localparam int VAL_W = 32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OUTER  = 3'd0;
  localparam logic [2:0] CFG_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_TILES  = 3'd3;
  localparam logic [2:0] CFG_LTR    = 3'd4;

  localparam logic [FN_W-1:0] RST_OUTER  = 29'd5;
  localparam logic [FN_W-1:0] RST_WIDTH  = 29'd4;
  localparam logic [FN_W-1:0] RST_HEIGHT = 29'd5;
  localparam logic [FN_W-1:0] RST_TILES  = 29'd6;
  localparam logic [FN_W-1:0] RST_LTR    = 29'd7;

  // Protobuf wire types.
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENDEL  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // A varint may span bytes 0..10; byte 10 must end it.
  localparam logic [3:0] VARINT_LAST = 4'd10;
  localparam logic [3:0] VARINT_FOLD = 4'd9;

  // Collected value slots.
  localparam logic [1:0] SLOT_WIDTH  = 2'd0;
  localparam logic [1:0] SLOT_HEIGHT = 2'd1;
  localparam logic [1:0] SLOT_TILES  = 2'd2;
  localparam logic [1:0] SLOT_LTR    = 2'd3;

  typedef enum logic [2:0] {
    OPH_TAG, OPH_VAL, OPH_LEN, OPH_LENT, OPH_SKIP, OPH_SUB, OPH_STOP
  } oph_t;

  typedef enum logic [2:0] {
    SPH_TAG, SPH_VAL, SPH_LEN, SPH_SKIP, SPH_DEAD
  } sph_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pcde_item_t;

  typedef struct packed {
    logic [FN_W-1:0] outer_fn;
    logic [FN_W-1:0] width_fn;
    logic [FN_W-1:0] height_fn;
    logic [FN_W-1:0] tiles_fn;
    logic [FN_W-1:0] ltr_fn;
  } pcde_cfg_t;

  typedef struct packed {
    logic                    ltr_seen;
    logic signed [VAL_W-1:0] ltr_value;
    logic [VAL_W-1:0]        tile_count;
    logic [VAL_W-1:0]        canvas_height;
    logic [VAL_W-1:0]        canvas_width;
    logic                    found;
  } pcde_result_t;

  // Tag field number (value >> 3) equals a field number register.
  function automatic logic fn_match(input logic [63:0] v, input logic [FN_W-1:0] fn);
    fn_match = (v[63:32] == 32'd0) && (v[31:3] == fn);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pcde_front.sv
// Input side: accepts blob bytes into a two-entry queue ahead of the parser.
`default_nettype none
module pcde_front
  import pcde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  output pcde_item_t      item,
  output logic            item_valid,
  input  wire logic       item_pop
);

  pcde_item_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  // Queue control.
  always_comb begin
    in_tready  = (cnt_r != 2'd2);
    push       = in_tvalid && in_tready;
    item_valid = (cnt_r != 2'd0);
    pop        = item_pop && item_valid;
    item       = q_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{data: in_tdata, last: in_tlast};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pcde_back.sv
// Parser: decodes varints and walks outer fields and the descriptor sub-message.
`default_nettype none
module pcde_back
  import pcde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  pcde_cfg_t       cfg,
  input  pcde_item_t      item,
  input  wire logic       item_valid,
  output logic            item_pop,
  input  wire logic       res_free,
  output logic            res_load,
  output pcde_result_t    res
);

  oph_t        oph_r, oph_nxt;
  sph_t        sph_r, sph_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  vcnt_r, vcnt_nxt;
  logic [63:0] orem_r, orem_nxt;
  logic [63:0] srem_r, srem_nxt;
  logic        slot_vld_r, slot_vld_nxt;
  logic [1:0]  slot_idx_r, slot_idx_nxt;
  logic [31:0] pval_r [4];
  logic [31:0] pval_nxt [4];
  logic [3:0]  pflg_r, pflg_nxt;
  logic [31:0] cval_r [4];
  logic [31:0] cval_nxt [4];
  logic [3:0]  cflg_r, cflg_nxt;

  logic        take;
  logic [7:0]  b;
  logic [6:0]  sh;
  logic [63:0] v;
  logic        vdone;
  logic        vfail;
  logic        vstep;
  logic        commit;
  logic        found;

  always_comb begin
    oph_nxt      = oph_r;
    sph_nxt      = sph_r;
    acc_nxt      = acc_r;
    vcnt_nxt     = vcnt_r;
    orem_nxt     = orem_r;
    srem_nxt     = srem_r;
    slot_vld_nxt = slot_vld_r;
    slot_idx_nxt = slot_idx_r;
    pval_nxt     = pval_r;
    pflg_nxt     = pflg_r;
    cval_nxt     = cval_r;
    cflg_nxt     = cflg_r;
    commit       = 1'b0;
    vstep        = 1'b0;

    // A last byte needs a free result slot; other bytes always flow.
    take     = item_valid && (!item.last || res_free);
    item_pop = take;
    b        = item.data;

    // Varint fold: seven bits at shift 7*count, dropped past bit 63.
    sh    = {vcnt_r, 3'b000} - {3'b000, vcnt_r};
    v     = (vcnt_r <= VARINT_FOLD) ? (acc_r | (64'(b[6:0]) << sh)) : acc_r;
    vdone = !b[7];
    vfail = b[7] && (vcnt_r == VARINT_LAST);

    if (take) begin
      unique case (oph_r)
        OPH_TAG: begin
          vstep = 1'b1;
          if (vdone) begin
            priority if (v[2:0] == WT_VARINT) begin
              oph_nxt = OPH_VAL;
            end else if (v[2:0] == WT_LENDEL) begin
              oph_nxt = fn_match(v, cfg.outer_fn) ? OPH_LENT : OPH_LEN;
            end else if (v[2:0] == WT_FIXED64) begin
              orem_nxt = 64'd8;
              oph_nxt  = OPH_SKIP;
            end else if (v[2:0] == WT_FIXED32) begin
              orem_nxt = 64'd4;
              oph_nxt  = OPH_SKIP;
            end else begin
              oph_nxt = OPH_STOP;
            end
          end else if (vfail) begin
            oph_nxt = OPH_STOP;
          end
        end
        OPH_VAL: begin
          vstep = 1'b1;
          if (vdone) begin
            oph_nxt = OPH_TAG;
          end else if (vfail) begin
            oph_nxt = OPH_STOP;
          end
        end
        OPH_LEN: begin
          vstep = 1'b1;
          if (vdone) begin
            if (v == 64'd0) begin
              oph_nxt = OPH_TAG;
            end else begin
              orem_nxt = v;
              oph_nxt  = OPH_SKIP;
            end
          end else if (vfail) begin
            oph_nxt = OPH_STOP;
          end
        end
        OPH_LENT: begin
          vstep = 1'b1;
          if (vdone) begin
            pflg_nxt     = 4'd0;
            sph_nxt      = SPH_TAG;
            slot_vld_nxt = 1'b0;
            if (v == 64'd0) begin
              commit  = 1'b1;
              oph_nxt = OPH_TAG;
            end else begin
              orem_nxt = v;
              oph_nxt  = OPH_SUB;
            end
          end else if (vfail) begin
            oph_nxt = OPH_STOP;
          end
        end
        OPH_SKIP: begin
          orem_nxt = orem_r - 64'd1;
          if (orem_r == 64'd1) begin
            oph_nxt = OPH_TAG;
          end
        end
        OPH_SUB: begin
          // Sub-message byte.
          unique case (sph_r)
            SPH_TAG: begin
              vstep = 1'b1;
              if (vdone) begin
                priority if (v[2:0] == WT_VARINT) begin
                  slot_vld_nxt = 1'b1;
                  priority if (fn_match(v, cfg.width_fn)) begin
                    slot_idx_nxt = SLOT_WIDTH;
                  end else if (fn_match(v, cfg.height_fn)) begin
                    slot_idx_nxt = SLOT_HEIGHT;
                  end else if (fn_match(v, cfg.tiles_fn)) begin
                    slot_idx_nxt = SLOT_TILES;
                  end else if (fn_match(v, cfg.ltr_fn)) begin
                    slot_idx_nxt = SLOT_LTR;
                  end else begin
                    slot_vld_nxt = 1'b0;
                  end
                  sph_nxt = SPH_VAL;
                end else if (v[2:0] == WT_LENDEL) begin
                  sph_nxt = SPH_LEN;
                end else if (v[2:0] == WT_FIXED64) begin
                  srem_nxt = 64'd8;
                  sph_nxt  = SPH_SKIP;
                end else if (v[2:0] == WT_FIXED32) begin
                  srem_nxt = 64'd4;
                  sph_nxt  = SPH_SKIP;
                end else begin
                  sph_nxt = SPH_DEAD;
                end
              end else if (vfail) begin
                sph_nxt = SPH_DEAD;
              end
            end
            SPH_VAL: begin
              vstep = 1'b1;
              if (vdone) begin
                if (slot_vld_r) begin
                  pval_nxt[slot_idx_r] = v[31:0];
                  pflg_nxt[slot_idx_r] = 1'b1;
                end
                sph_nxt = SPH_TAG;
              end else if (vfail) begin
                sph_nxt = SPH_DEAD;
              end
            end
            SPH_LEN: begin
              vstep = 1'b1;
              if (vdone) begin
                if (v == 64'd0) begin
                  sph_nxt = SPH_TAG;
                end else begin
                  srem_nxt = v;
                  sph_nxt  = SPH_SKIP;
                end
              end else if (vfail) begin
                sph_nxt = SPH_DEAD;
              end
            end
            SPH_SKIP: begin
              srem_nxt = srem_r - 64'd1;
              if (srem_r == 64'd1) begin
                sph_nxt = SPH_TAG;
              end
            end
            SPH_DEAD: begin
            end
            default: begin
              sph_nxt = SPH_DEAD;
            end
          endcase
          orem_nxt = orem_r - 64'd1;
          if (orem_r == 64'd1) begin
            commit  = 1'b1;
            oph_nxt = OPH_TAG;
          end
        end
        OPH_STOP: begin
        end
        default: begin
          oph_nxt = OPH_STOP;
        end
      endcase
    end

    // Shared varint accumulator.
    if (vstep) begin
      if (vdone || vfail) begin
        acc_nxt  = 64'd0;
        vcnt_nxt = 4'd0;
      end else begin
        acc_nxt  = v;
        vcnt_nxt = vcnt_r + 4'd1;
      end
    end

    // The whole sub-message arrived: move pending values to committed.
    if (commit) begin
      for (int i = 0; i < 4; i++) begin
        if (pflg_nxt[i]) begin
          cval_nxt[i] = pval_nxt[i];
        end
      end
      cflg_nxt     = cflg_r | pflg_nxt;
      pflg_nxt     = 4'd0;
      slot_vld_nxt = 1'b0;
      sph_nxt      = SPH_TAG;
      acc_nxt      = 64'd0;
      vcnt_nxt     = 4'd0;
    end

    // Result from the committed values, including this byte's commit.
    found = cflg_nxt[SLOT_WIDTH] && cflg_nxt[SLOT_HEIGHT] &&
            (cval_nxt[SLOT_WIDTH] != 32'd0) && (cval_nxt[SLOT_HEIGHT] != 32'd0);
    res.found         = found;
    res.canvas_width  = found ? cval_nxt[SLOT_WIDTH] : 32'd0;
    res.canvas_height = found ? cval_nxt[SLOT_HEIGHT] : 32'd0;
    res.tile_count    = (found && cflg_nxt[SLOT_TILES]) ? cval_nxt[SLOT_TILES] : 32'd0;
    res.ltr_value     = cflg_nxt[SLOT_LTR] ? cval_nxt[SLOT_LTR] : 32'sd0;
    res.ltr_seen      = cflg_nxt[SLOT_LTR];
    res_load          = take && item.last;

    // End of blob: clear parse state for the next one.
    if (res_load) begin
      oph_nxt      = OPH_TAG;
      sph_nxt      = SPH_TAG;
      acc_nxt      = 64'd0;
      vcnt_nxt     = 4'd0;
      slot_vld_nxt = 1'b0;
      pflg_nxt     = 4'd0;
      cflg_nxt     = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oph_r      <= OPH_TAG;
      sph_r      <= SPH_TAG;
      acc_r      <= 64'd0;
      vcnt_r     <= 4'd0;
      slot_vld_r <= 1'b0;
      pflg_r     <= 4'd0;
      cflg_r     <= 4'd0;
    end else begin
      oph_r      <= oph_nxt;
      sph_r      <= sph_nxt;
      acc_r      <= acc_nxt;
      vcnt_r     <= vcnt_nxt;
      slot_vld_r <= slot_vld_nxt;
      pflg_r     <= pflg_nxt;
      cflg_r     <= cflg_nxt;
    end
  end

  // Counters and value slots are only read when their phase or flag says so.
  always_ff @(posedge clk) begin
    orem_r     <= orem_nxt;
    srem_r     <= srem_nxt;
    slot_idx_r <= slot_idx_nxt;
    pval_r     <= pval_nxt;
    cval_r     <= cval_nxt;
  end

  // The varint byte count never passes the eleventh byte.
  a_vcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VARINT_LAST)
    else $error("varint byte count out of range");

  // After the last byte the parser starts the next blob clean.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (oph_r == OPH_TAG) && (cflg_r == 4'd0) && (vcnt_r == 4'd0))
    else $error("parse state not cleared after last byte");

  // A result is produced only while its slot is free.
  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> res_free)
    else $error("result loaded into a busy slot");

  // Pending values exist only while inside a sub-message.
  a_pending_scope: assert property (@(posedge clk) disable iff (!rst_n)
    (pflg_r != 4'd0) |-> (oph_r == OPH_SUB))
    else $error("pending values outside a sub-message");

endmodule
`default_nettype wire

FILE: rtl/protobuf_canvas_dims_extract_top.sv
// Top level of the canvas descriptor extractor: config registers, queue, parser, result register.
//
//  Channel | Signals                          | Request
//  --------+----------------------------------+-------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata/in_tlast | one blob byte, in_tlast on the final byte
//  out     | out_tvalid/out_tready/out_tdata  | one descriptor result per blob
//  cfg     | cfg_we/cfg_addr/cfg_data         | field number register write
//
// One byte per cycle in and through the parser, unless a last byte waits on a held result.
// With an empty queue, the last byte passes the queue register and then the result register
// before out_tvalid rises; each older byte still waiting in the queue is decoded ahead of it.
// Reset is synchronous, active low, and restores the default field numbers.
// A held result stalls the parser only at the next blob's last byte; the
// two-entry queue keeps in_tready high meanwhile until it fills.
`default_nettype none
module protobuf_canvas_dims_extract_top
  import pcde_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // blob_byte
  input  wire logic          in_tlast,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [135:0]       out_tdata,  // found, canvas_width, canvas_height,
                                         // tile_count, ltr_value, ltr_seen, pad
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_addr,
  input  wire logic [FN_W-1:0] cfg_data
);

  pcde_cfg_t    cfg_r, cfg_nxt;
  pcde_item_t   item;
  logic         item_valid;
  logic         item_pop;
  logic         res_free;
  logic         res_load;
  pcde_result_t res;
  pcde_result_t res_r;
  logic         out_valid_r, out_valid_nxt;

  // Configuration writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OUTER:  cfg_nxt.outer_fn  = cfg_data;
        CFG_WIDTH:  cfg_nxt.width_fn  = cfg_data;
        CFG_HEIGHT: cfg_nxt.height_fn = cfg_data;
        CFG_TILES:  cfg_nxt.tiles_fn  = cfg_data;
        CFG_LTR:    cfg_nxt.ltr_fn    = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{outer_fn: RST_OUTER, width_fn: RST_WIDTH, height_fn: RST_HEIGHT,
                 tiles_fn: RST_TILES, ltr_fn: RST_LTR};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcde_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  pcde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res)
  );

  // Result register.
  always_comb begin
    res_free      = !out_valid_r || out_tready;
    out_valid_nxt = res_load || (out_valid_r && !out_tready);
    out_tvalid    = out_valid_r;
    out_tdata     = {6'd0, res_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

FILE: verif/protobuf_canvas_dims_extract_checker.sv
// Checker for the canvas descriptor extractor: predicts each blob result and compares it.
`timescale 1ns / 100ps
module protobuf_canvas_dims_extract_checker
  import pcde_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  wire logic            in_tready,
  input  wire logic [7:0]      in_tdata,
  input  wire logic            in_tlast,
  input  wire logic            out_tvalid,
  input  wire logic            out_tready,
  input  wire logic [135:0]    out_tdata,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_addr,
  input  wire logic [FN_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   results_waiting
);

  typedef enum int {VI_MORE, VI_DONE, VI_FAIL} vi_t;

  // Predictor copy of the field number registers and the parser state.
  logic [FN_W-1:0] fn_reg [5];
  oph_t            outer_ph;
  sph_t            sub_ph;
  logic [63:0]     acc;
  int              shift;
  logic [63:0]     outer_left;
  logic [63:0]     sub_left;
  int              slot;
  logic [31:0]     pend_val [4];
  logic [3:0]      pend_flg;
  logic [31:0]     kept_val [4];
  logic [3:0]      kept_flg;
  bit              stopped;
  pcde_result_t    descriptors_due [$];

  task automatic clear_parse();
    outer_ph = OPH_TAG;
    sub_ph = SPH_TAG;
    acc = '0;
    shift = 0;
    outer_left = '0;
    sub_left = '0;
    slot = 0;
    pend_flg = '0;
    kept_flg = '0;
    stopped = 0;
    for (int i = 0; i < 4; i++) begin
      pend_val[i] = '0;
      kept_val[i] = '0;
    end
  endtask

  // One base-128 step; a continuation bit on the eleventh byte fails.
  function automatic vi_t fold(input logic [7:0] b, output logic [63:0] v);
    v = '0;
    if (shift < 64) acc |= {57'd0, b[6:0]} << shift;
    shift += 7;
    if (!b[7]) begin
      v = acc;
      acc = '0;
      shift = 0;
      return VI_DONE;
    end
    if (shift > 70) begin
      acc = '0;
      shift = 0;
      return VI_FAIL;
    end
    return VI_MORE;
  endfunction

  // Width wins over height, then tiles, then LTR.
  function automatic int slot_of(input logic [63:0] fnum);
    if (fnum == {35'd0, fn_reg[CFG_WIDTH]}) return 1;
    if (fnum == {35'd0, fn_reg[CFG_HEIGHT]}) return 2;
    if (fnum == {35'd0, fn_reg[CFG_TILES]}) return 3;
    if (fnum == {35'd0, fn_reg[CFG_LTR]}) return 4;
    return 0;
  endfunction

  task automatic sub_byte(input logic [7:0] b);
    logic [63:0] v;
    vi_t r;
    case (sub_ph)
      SPH_TAG: begin
        r = fold(b, v);
        if (r == VI_DONE) begin
          case (v[2:0])
            WT_VARINT: begin
              slot = slot_of(v >> 3);
              sub_ph = SPH_VAL;
            end
            WT_LENDEL: sub_ph = SPH_LEN;
            WT_FIXED64: begin
              sub_left = 8;
              sub_ph = SPH_SKIP;
            end
            WT_FIXED32: begin
              sub_left = 4;
              sub_ph = SPH_SKIP;
            end
            default: sub_ph = SPH_DEAD;
          endcase
        end else if (r == VI_FAIL) sub_ph = SPH_DEAD;
      end
      SPH_VAL: begin
        r = fold(b, v);
        if (r == VI_DONE) begin
          if (slot != 0) begin
            pend_val[slot-1] = v[31:0];
            pend_flg[slot-1] = 1'b1;
          end
          sub_ph = SPH_TAG;
        end else if (r == VI_FAIL) sub_ph = SPH_DEAD;
      end
      SPH_LEN: begin
        r = fold(b, v);
        if (r == VI_DONE) begin
          if (v == 0) sub_ph = SPH_TAG;
          else begin
            sub_left = v;
            sub_ph = SPH_SKIP;
          end
        end else if (r == VI_FAIL) sub_ph = SPH_DEAD;
      end
      SPH_SKIP: begin
        sub_left--;
        if (sub_left == 0) sub_ph = SPH_TAG;
      end
      default: ;
    endcase
  endtask

  // A sub-message that completed inside the blob overwrites earlier values.
  task automatic commit_sub();
    for (int i = 0; i < 4; i++) begin
      if (pend_flg[i]) begin
        kept_val[i] = pend_val[i];
        kept_flg[i] = 1'b1;
      end
    end
    pend_flg = '0;
    slot = 0;
    sub_ph = SPH_TAG;
    acc = '0;
    shift = 0;
  endtask

  task automatic outer_byte(input logic [7:0] b);
    logic [63:0] v;
    vi_t r;
    if (stopped) return;
    case (outer_ph)
      OPH_TAG: begin
        r = fold(b, v);
        if (r == VI_DONE) begin
          case (v[2:0])
            WT_VARINT: outer_ph = OPH_VAL;
            WT_LENDEL: outer_ph = ((v >> 3) == {35'd0, fn_reg[CFG_OUTER]}) ? OPH_LENT : OPH_LEN;
            WT_FIXED64: begin
              outer_left = 8;
              outer_ph = OPH_SKIP;
            end
            WT_FIXED32: begin
              outer_left = 4;
              outer_ph = OPH_SKIP;
            end
            default: stopped = 1;
          endcase
        end else if (r == VI_FAIL) stopped = 1;
      end
      OPH_VAL: begin
        r = fold(b, v);
        if (r == VI_DONE) outer_ph = OPH_TAG;
        else if (r == VI_FAIL) stopped = 1;
      end
      OPH_LEN: begin
        r = fold(b, v);
        if (r == VI_DONE) begin
          if (v == 0) outer_ph = OPH_TAG;
          else begin
            outer_left = v;
            outer_ph = OPH_SKIP;
          end
        end else if (r == VI_FAIL) stopped = 1;
      end
      OPH_LENT: begin
        r = fold(b, v);
        if (r == VI_DONE) begin
          pend_flg = '0;
          for (int i = 0; i < 4; i++) pend_val[i] = '0;
          sub_ph = SPH_TAG;
          slot = 0;
          if (v == 0) begin
            commit_sub();
            outer_ph = OPH_TAG;
          end else begin
            outer_left = v;
            outer_ph = OPH_SUB;
          end
        end else if (r == VI_FAIL) stopped = 1;
      end
      OPH_SKIP: begin
        outer_left--;
        if (outer_left == 0) outer_ph = OPH_TAG;
      end
      OPH_SUB: begin
        sub_byte(b);
        outer_left--;
        if (outer_left == 0) begin
          commit_sub();
          outer_ph = OPH_TAG;
        end
      end
      default: stopped = 1;
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    pcde_result_t d;
    bit hit;
    outer_byte(b);
    if (!last) return;
    hit = kept_flg[SLOT_WIDTH] && kept_flg[SLOT_HEIGHT] &&
          kept_val[SLOT_WIDTH] != 0 && kept_val[SLOT_HEIGHT] != 0;
    d.found = hit;
    d.canvas_width = hit ? kept_val[SLOT_WIDTH] : '0;
    d.canvas_height = hit ? kept_val[SLOT_HEIGHT] : '0;
    d.tile_count = (hit && kept_flg[SLOT_TILES]) ? kept_val[SLOT_TILES] : '0;
    d.ltr_value = kept_flg[SLOT_LTR] ? kept_val[SLOT_LTR] : '0;
    d.ltr_seen = kept_flg[SLOT_LTR];
    descriptors_due.push_back(d);
    clear_parse();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: descriptor mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input logic [135:0] word);
    pcde_result_t got;
    pcde_result_t want;
    got = pcde_result_t'(word[129:0]);
    if (descriptors_due.size() == 0) begin
      report("unexpected result", got.canvas_width, 0);
      return;
    end
    want = descriptors_due.pop_front();
    if (got.found !== want.found) report("found", got.found, want.found);
    if (got.canvas_width !== want.canvas_width)
      report("canvas_width", got.canvas_width, want.canvas_width);
    if (got.canvas_height !== want.canvas_height)
      report("canvas_height", got.canvas_height, want.canvas_height);
    if (got.tile_count !== want.tile_count) report("tile_count", got.tile_count, want.tile_count);
    if (got.ltr_value !== want.ltr_value) report("ltr_value", got.ltr_value, want.ltr_value);
    if (got.ltr_seen !== want.ltr_seen) report("ltr_seen", got.ltr_seen, want.ltr_seen);
  endtask

  initial fail_count = 0;

  // Follow register writes, accepted bytes and accepted results.
  always @(posedge clk) begin
    if (!rst_n) begin
      fn_reg[CFG_OUTER] = RST_OUTER;
      fn_reg[CFG_WIDTH] = RST_WIDTH;
      fn_reg[CFG_HEIGHT] = RST_HEIGHT;
      fn_reg[CFG_TILES] = RST_TILES;
      fn_reg[CFG_LTR] = RST_LTR;
      clear_parse();
      descriptors_due.delete();
    end else begin
      if (cfg_we && cfg_addr <= CFG_LTR) fn_reg[cfg_addr] = cfg_data;
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
    end
    results_waiting = descriptors_due.size();
  end

endmodule

FILE: verif/protobuf_canvas_dims_extract_top_tb.sv
// Testbench top for the canvas descriptor extractor: stimulus, idling and verdict.
`timescale 1ns / 100ps
module protobuf_canvas_dims_extract_top_tb;
  import pcde_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [FN_W-1:0] FN_MAX = {FN_W{1'b1}};

  logic            clk = 0;
  logic            rst_n = 0;
  logic            in_tvalid = 0;
  logic            in_tready;
  logic [7:0]      in_tdata = '0;
  logic            in_tlast = 0;
  logic            out_tvalid;
  logic            out_tready = 0;
  logic [135:0]    out_tdata;
  logic            cfg_we = 0;
  logic [2:0]      cfg_addr = '0;
  logic [FN_W-1:0] cfg_data = '0;
  int              fail_count;
  int              results_waiting;
  int              cycles = 0;
  int              bytes_sent = 0;
  int              blobs_sent = 0;
  bit              idle_on = 1;
  int              stall_left = 0;
  logic [FN_W-1:0] fn_now [5];

  protobuf_canvas_dims_extract_top dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_data
  );

  protobuf_canvas_dims_extract_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_data,
    .fail_count, .results_waiting
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("protobuf_canvas_dims_extract_top_tb: FAIL");
      $finish;
    end
  end

  // Result side backpressure in random bursts while idling is on.
  always @(posedge clk) begin
    if (!idle_on) out_tready <= 1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 0;
    end else out_tready <= 1;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 15) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // The last byte stays driven until the next byte or a drain replaces it.
  task automatic send_blob(input logic [7:0] blob [$]);
    if (blob.size() == 0) blob.push_back(8'($urandom_range(0, 255)));
    foreach (blob[i]) send_byte(blob[i], i == blob.size() - 1);
    blobs_sent++;
  endtask

  // The caller drops cfg_we after its last write.
  task automatic write_reg(input logic [2:0] idx, input logic [FN_W-1:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    fn_now[idx] = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void put_varint(ref logic [7:0] q [$], input logic [63:0] v);
    do begin
      q.push_back({(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endfunction

  function automatic void put_tag(ref logic [7:0] q [$], input logic [63:0] fnum,
                                  input logic [2:0] wt);
    put_varint(q, (fnum << 3) | {61'd0, wt});
  endfunction

  // Varint values of random byte length, with zero and all-ones now and then.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int n;
    v = {$urandom, $urandom};
    n = $urandom_range(1, 64);
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      default: return (n == 64) ? v : v & ((64'd1 << n) - 64'd1);
    endcase
  endfunction

  // Ten continuation bytes, then an end byte or a failing continuation.
  function automatic void put_long_varint(ref logic [7:0] q [$], input bit bad);
    for (int i = 0; i < 10; i++) q.push_back({1'b1, 7'($urandom_range(0, 127))});
    q.push_back({bad, 7'($urandom_range(0, 127))});
  endfunction

  function automatic void build_sub(ref logic [7:0] q [$]);
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          put_tag(q, 64'(fn_now[$urandom_range(CFG_WIDTH, CFG_LTR)]), WT_VARINT);
          put_varint(q, rand_value());
        end
        8: begin
          put_tag(q, 64'($urandom_range(0, 40)), WT_VARINT);
          put_varint(q, rand_value());
        end
        9: begin
          put_tag(q, 64'($urandom_range(1, 40)), WT_FIXED64);
          repeat (8) q.push_back(8'($urandom_range(0, 255)));
        end
        10: begin
          put_tag(q, 64'(fn_now[$urandom_range(CFG_WIDTH, CFG_LTR)]), WT_FIXED32);
          repeat (4) q.push_back(8'($urandom_range(0, 255)));
        end
        11: begin
          int len;
          len = $urandom_range(0, 5);
          put_tag(q, 64'($urandom_range(1, 40)), WT_LENDEL);
          put_varint(q, 64'(len));
          repeat (len) q.push_back(8'($urandom_range(0, 255)));
        end
        12: begin
          put_tag(q, 64'(fn_now[$urandom_range(CFG_WIDTH, CFG_LTR)]), WT_VARINT);
          put_long_varint(q, $urandom_range(0, 3) == 0);
        end
        13: begin
          // Unknown wire type kills the rest of this sub-message.
          put_tag(q, 64'($urandom_range(1, 40)), $urandom_range(0, 1) ? 3'd3 : 3'd7);
          q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          put_tag(q, 64'($urandom_range(1, 40)), WT_LENDEL);
          put_varint(q, 64'($urandom_range(6, 40)));
        end
      endcase
    end
  endfunction

  function automatic void build_blob(ref logic [7:0] q [$]);
    int n;
    logic [7:0] sub [$];
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5: begin
          int len;
          sub.delete();
          build_sub(sub);
          len = sub.size();
          // Mostly exact lengths; some short, some too long, which can overrun the blob.
          case ($urandom_range(0, 9))
            0: len = len + $urandom_range(1, 30);
            1: len = $urandom_range(0, len);
            default: ;
          endcase
          put_tag(q, 64'(fn_now[CFG_OUTER]), WT_LENDEL);
          put_varint(q, 64'(len));
          foreach (sub[j]) q.push_back(sub[j]);
        end
        6: begin
          put_tag(q, 64'($urandom_range(1, 40)), WT_VARINT);
          put_varint(q, rand_value());
        end
        7: begin
          put_tag(q, 64'($urandom_range(1, 40)), $urandom_range(0, 1) ? WT_FIXED32 : WT_FIXED64);
          repeat (($urandom_range(0, 1)) ? 4 : 8) q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          put_tag(q, 64'(fn_now[CFG_OUTER]) + 64'd1, WT_LENDEL);
          sub.delete();
          build_sub(sub);
          put_varint(q, 64'(sub.size()));
          foreach (sub[j]) q.push_back(sub[j]);
        end
        9: put_long_varint(q, $urandom_range(0, 1) == 1);
        10: q.push_back(8'($urandom_range(0, 255)));
        default: repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // Directed blobs, then phases of random blobs under different field numbers.
  initial begin
    logic [7:0] q [$];
    fn_now[CFG_OUTER] = RST_OUTER;
    fn_now[CFG_WIDTH] = RST_WIDTH;
    fn_now[CFG_HEIGHT] = RST_HEIGHT;
    fn_now[CFG_TILES] = RST_TILES;
    fn_now[CFG_LTR] = RST_LTR;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Single byte blobs with all bits low and high.
    q = '{8'h00};
    send_blob(q);
    q = '{8'hFF};
    send_blob(q);
    // A complete descriptor with width, height, tiles and LTR.
    q = '{8'h2A, 8'h08, 8'h20, 8'h05, 8'h28, 8'h07, 8'h30, 8'h02, 8'h38, 8'h01};
    send_blob(q);
    // Cut-off descriptor: the length runs past the end of the blob.
    q = '{8'h2A, 8'h09, 8'h20, 8'h05, 8'h28, 8'h07};
    send_blob(q);
    // Eleven byte varint that ends, then one that fails.
    q.delete();
    q.push_back(8'h08);
    put_long_varint(q, 0);
    send_blob(q);
    q.delete();
    q.push_back(8'h08);
    put_long_varint(q, 1);
    send_blob(q);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: begin
            write_reg(CFG_OUTER, 1);
            write_reg(CFG_WIDTH, 1);
            write_reg(CFG_HEIGHT, 2);
            write_reg(CFG_TILES, 3);
            write_reg(CFG_LTR, 4);
          end
          2: begin
            write_reg(CFG_OUTER, FN_MAX);
            write_reg(CFG_WIDTH, FN_MAX);
            write_reg(CFG_HEIGHT, FN_MAX - FN_W'(1));
            write_reg(CFG_TILES, 1);
            write_reg(CFG_LTR, FN_MAX);
          end
          3: begin
            // Colliding numbers exercise the slot priority.
            write_reg(CFG_WIDTH, 9);
            write_reg(CFG_HEIGHT, 9);
            write_reg(CFG_TILES, 10);
            write_reg(CFG_LTR, 10);
          end
          default: begin
            for (int r = CFG_OUTER; r <= CFG_LTR; r++)
              write_reg(3'(r), FN_W'($urandom_range(1, 2000)));
          end
        endcase
        cfg_we <= 0;
      end
      if (phase == 5) idle_on = 0;
      for (int k = 0; k < 4; k++) begin
        q.delete();
        build_blob(q);
        send_blob(q);
      end
      drain();
    end

    $display("Covered %0d blobs, %0d bytes, six field number settings with idling and stalls.",
             blobs_sent, bytes_sent);
    if (fail_count == 0) $display("protobuf_canvas_dims_extract_top_tb: PASS");
    else $display("protobuf_canvas_dims_extract_top_tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/pcde_pkg.sv
rtl/pcde_front.sv
rtl/pcde_back.sv
rtl/protobuf_canvas_dims_extract_top.sv
verif/protobuf_canvas_dims_extract_checker.sv
verif/protobuf_canvas_dims_extract_top_tb.sv
